// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Every check is clocked on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define ASSERT_IMPL(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// The condition must never be true.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- hw/rtl/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and codes for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // request modes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // character codes
    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_RETURN    = 8'h0D;
    localparam logic [7:0] CHR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_PRINTABLE = 8'h20;
    localparam logic [7:0] CHR_BLANK     = 8'h20;

    // input request
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in;

    // result
    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic [10:0] cursor_offset;
        logic [15:0] read_data;
        logic        scrolled;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch request payload
        logic home;        // cursor to row 0, column 0
        logic exec_put;    // interpret character, update cursor
        logic rd_cell;     // read the addressed cell
        logic copy;        // scroll copy step
        logic blank;       // blank fill step
        logic cnt_zero;    // sweep counter to first cell
        logic cnt_last;    // sweep counter to first cell of last row
        logic cnt_inc;     // sweep counter step
        logic offs_upd;    // recompute linear cursor offset
        logic out_load;    // capture result
        logic out_read;    // result carries read data
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scroll_now;  // put overflows the last row
        logic copy_end;    // final copy step
        logic blank_end;   // final blank step
    } t_status;

endpackage

// ----- hw/rtl/tcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer for one request at a time: decode, store sweeps, result hand-off.
// ----------------------------------------------------------------------------
module tcce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_in_mode,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  tcce_pkg::t_status i_status,
    output tcce_pkg::t_cmd    o_cmd
);
    import tcce_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_BLANK,
        S_READ,
        S_OFFS,
        S_DONE
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_mode;
    logic       r_out_valid;
    logic       in_acc;
    logic       slot_free;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_read = (r_mode == MODE_READ);
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_in_mode == MODE_PUT) begin
                        n_state = S_EXEC;
                    end else if (i_in_mode == MODE_CLEAR) begin
                        o_cmd.home     = 1'b1;
                        o_cmd.cnt_zero = 1'b1;
                        n_state        = S_BLANK;
                    end else if (i_in_mode == MODE_READ) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_EXEC: begin
                o_cmd.exec_put = 1'b1;
                if (i_status.scroll_now) begin
                    o_cmd.cnt_zero = 1'b1;
                    n_state        = S_COPY;
                end else begin
                    n_state = S_OFFS;
                end
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_status.copy_end) begin
                    o_cmd.cnt_last = 1'b1;
                    n_state        = S_BLANK;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_BLANK: begin
                o_cmd.blank = 1'b1;
                if (i_status.blank_end) begin
                    n_state = S_OFFS;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd_cell = 1'b1;
                n_state       = S_DONE;
            end
            S_OFFS: begin
                o_cmd.offs_upd = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_PUT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_mode <= i_in_mode;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/tcce_dp.sv -----
// ----------------------------------------------------------------------------
// tcce_dp
// Text store, cursor registers, sweep counter and result register.
// ----------------------------------------------------------------------------
module tcce_dp #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 24,
    parameter int TAB_STOP = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcce_pkg::t_in     i_in_data,
    input  logic [7:0]        i_attr,
    input  tcce_pkg::t_cmd    i_cmd,
    output tcce_pkg::t_status o_status,
    output tcce_pkg::t_out    o_out_data
);
    import tcce_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
    localparam int PH_W   = $clog2(TAB_STOP);

    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] BLANK_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_SPAN   = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0]  COL_TAB    = COL_W'(TAB_STOP);
    localparam logic [ROW_W-1:0]  ROW_LIMIT  = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [PH_W-1:0]   PH_LAST    = PH_W'(TAB_STOP - 1);
    localparam logic [PH_W-1:0]   PH_WRAP    = PH_W'((COLUMNS - 1) % TAB_STOP);

    logic [15:0]       r_store [CELLS];
    logic [15:0]       r_rd_data;
    logic [7:0]        r_code;
    logic [10:0]       r_index;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [PH_W-1:0]   r_phase;
    logic [ADDR_W-1:0] r_offset;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_scroll;
    t_out              r_out;

    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic [PH_W-1:0]   n_phase;
    logic              put_wr;
    logic              put_scroll;
    logic              index_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign index_ok = (32'(r_index) < 32'(CELLS));

    // character interpretation and cursor settle
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_phase    = r_phase;
        put_wr     = 1'b0;
        put_scroll = 1'b0;
        priority if (r_code == CHR_NEWLINE) begin
            n_col   = '0;
            n_phase = '0;
            n_row   = r_row + 1'b1;
        end else if (r_code == CHR_RETURN) begin
            n_col   = '0;
            n_phase = '0;
        end else if (r_code == CHR_BACKSPACE) begin
            if (r_col != '0) begin
                n_col   = r_col - 1'b1;
                n_phase = (r_phase == '0) ? PH_LAST : r_phase - 1'b1;
            end else if (r_row != '0) begin
                n_row   = r_row - 1'b1;
                n_col   = COL_LAST;
                n_phase = PH_WRAP;
            end
        end else if (r_code == CHR_TAB) begin
            n_col   = r_col + COL_TAB - COL_W'(r_phase);
            n_phase = '0;
        end else if (r_code < CHR_PRINTABLE) begin
            n_col = r_col;
        end else begin
            put_wr  = 1'b1;
            n_col   = r_col + 1'b1;
            n_phase = (r_phase == PH_LAST) ? '0 : r_phase + 1'b1;
        end
        // wrap past the last column
        if (n_col >= COL_LIMIT) begin
            n_col   = '0;
            n_phase = '0;
            n_row   = n_row + 1'b1;
        end
        // overflow past the last row
        if (n_row >= ROW_LIMIT) begin
            n_row      = ROW_LAST;
            put_scroll = 1'b1;
        end
    end

    assign o_status.scroll_now = put_scroll;
    assign o_status.copy_end   = (r_cnt == COPY_LAST);
    assign o_status.blank_end  = (r_cnt == BLANK_LAST);

    // store port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_offset;
        wr_data = {i_attr, r_code};
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(r_index);
        if (i_cmd.exec_put) begin
            wr_en = put_wr;
        end else if (i_cmd.copy) begin
            wr_en   = (r_cnt != '0);
            wr_addr = r_cnt - 1'b1;
            wr_data = r_rd_data;
            rd_en   = !o_status.copy_end;
            rd_addr = r_cnt + ROW_SPAN;
        end else if (i_cmd.blank) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt;
            wr_data = {i_attr, CHR_BLANK};
        end else if (i_cmd.rd_cell) begin
            rd_en = index_ok;
        end
    end

    // text store write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
    end

    // text store read port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code  <= i_in_data.char_code;
            r_index <= i_in_data.cell_index;
        end
    end

    // cursor, offset, sweep counter, scroll flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_phase  <= '0;
            r_offset <= '0;
            r_cnt    <= '0;
            r_scroll <= 1'b0;
        end else begin
            if (i_cmd.home) begin
                r_row   <= '0;
                r_col   <= '0;
                r_phase <= '0;
            end else if (i_cmd.exec_put) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_phase <= n_phase;
            end
            if (i_cmd.offs_upd) begin
                r_offset <= ADDR_W'(32'(r_row) * COLUMNS + 32'(r_col));
            end
            if (i_cmd.cnt_zero) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_last) begin
                r_cnt <= COPY_LAST;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.load) begin
                r_scroll <= 1'b0;
            end else if (i_cmd.exec_put) begin
                r_scroll <= put_scroll;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.cursor_row    <= 5'(r_row);
            r_out.cursor_column <= 7'(r_col);
            r_out.cursor_offset <= 11'(r_offset);
            r_out.read_data     <= (i_cmd.out_read && index_ok) ? r_rd_data : 16'h0000;
            r_out.scrolled      <= r_scroll;
        end
    end

    assign o_out_data = r_out;

endmodule

// ----- hw/rtl/text_console_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Character terminal engine: text store, cursor control, scroll and clear.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives one result. A put request passes
// through decode, offset update and result load; a read through store read and
// result load; mode 3 goes straight to result load. A put that runs off the
// last row scrolls the store through its single read and single write port,
// one cell a cycle. A clear writes one cell a cycle. The next request is taken
// as soon as the result is loaded, even while that result is still stalled at
// the output.
`include "assert_macros.svh"

module text_console_cursor_engine #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 24,
    parameter int TAB_STOP = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request channel
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tcce_pkg::t_in  i_in_data,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tcce_pkg::t_out o_out_data,
    // register port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import tcce_pkg::*;

    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    logic [3:0] r_fg;
    logic [3:0] r_bg;
    logic       reg_sel;
    logic       reg_wr;
    t_cmd       cmd;
    t_status    status;

    // color registers
    assign reg_sel = paddr[2];
    assign reg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd7;
            r_bg <= 4'd0;
        end else if (reg_wr) begin
            if (reg_sel == REG_FG) begin
                r_fg <= pwdata[3:0];
            end else begin
                r_bg <= pwdata[3:0];
            end
        end
    end

    assign prdata = (reg_sel == REG_BG) ? {28'd0, r_bg} : {28'd0, r_fg};

    tcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_in_data.mode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tcce_dp #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_attr     ({r_bg, r_fg}),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

    // a new result never overwrites one still waiting at the output
    `ASSERT_IMPL(a_no_result_overwrite, cmd.out_load, !o_out_valid || !i_out_stall, "result lost")
    // the store is never written while requests are being taken
    `ASSERT_IMPL(a_idle_no_write, !o_in_stall, !(cmd.exec_put || cmd.copy || cmd.blank), "idle write")
    // copy and blank sweeps never overlap
    `ASSERT_NEVER(a_sweep_exclusive, cmd.copy && cmd.blank, "sweeps overlap")

endmodule

// ----- tb/text_console_cursor_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_tb
// Self-checking bench for the text console cursor engine.
// ----------------------------------------------------------------------------
// A console model in the bench tracks the text store, the cursor and the
// colors. Each accepted request updates the model and queues the expected
// result. A checker compares every accepted result field by field. Stimulus is
// a register pass, a directed pass over the control codes and corner cases, a
// back-pressure pass, then line-shaped random traffic under several colors.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;
    import tcce_pkg::*;

    localparam int SCREEN_COLS     = 80;
    localparam int SCREEN_ROWS     = 24;
    localparam int TAB_WIDTH       = 8;
    localparam int SCREEN_CELLS    = SCREEN_COLS * SCREEN_ROWS;
    localparam int RANDOM_ITEMS    = 1250;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 32;

    localparam logic [1:0]  MODE_UNUSED    = 2'd3;
    localparam logic [10:0] INDEX_ALL_ONES = 11'h7FF;
    localparam logic [2:0]  ADDR_FOREGROUND = 3'd0;
    localparam logic [2:0]  ADDR_BACKGROUND = 3'd4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // console model state
    logic [15:0] screen_cells [SCREEN_CELLS];
    bit          cell_written [SCREEN_CELLS];
    int          cursor_r;
    int          cursor_c;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;

    t_out expected_results [$];
    int   mismatch_count;
    int   useful_items;
    int   quiet_cycles;
    int   hold_off_len;
    bit   send_idling;
    bit   recv_idling;

    text_console_cursor_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // Apply one request to the console model and return the result it gives.
    function automatic t_out advance_console(t_in req);
        t_out        res;
        bit          moved;
        logic [15:0] attr_cell;
        int          i;
        attr_cell = {bg_color, fg_color, 8'h00};
        res = '0;
        moved = 1'b1;
        case (req.mode)
            MODE_PUT: begin
                if (req.char_code == CHR_NEWLINE) begin
                    cursor_c = 0;
                    cursor_r++;
                end else if (req.char_code == CHR_RETURN) begin
                    cursor_c = 0;
                end else if (req.char_code == CHR_BACKSPACE) begin
                    // non-erasing, wraps back to the end of the previous row
                    if (cursor_c > 0) begin
                        cursor_c--;
                    end else if (cursor_r > 0) begin
                        cursor_r--;
                        cursor_c = SCREEN_COLS - 1;
                    end
                end else if (req.char_code == CHR_TAB) begin
                    cursor_c += TAB_WIDTH - (cursor_c % TAB_WIDTH);
                end else if (req.char_code < CHR_PRINTABLE) begin
                    moved = 1'b0;
                end else begin
                    screen_cells[cursor_r * SCREEN_COLS + cursor_c] = attr_cell | req.char_code;
                    cell_written[cursor_r * SCREEN_COLS + cursor_c] = 1'b1;
                    cursor_c++;
                end
                // column overflow wraps, row overflow scrolls one row
                if (moved && cursor_c >= SCREEN_COLS) begin
                    cursor_c = 0;
                    cursor_r++;
                end
                if (moved && cursor_r >= SCREEN_ROWS) begin
                    for (i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
                        screen_cells[i] = screen_cells[i + SCREEN_COLS];
                        cell_written[i] = cell_written[i + SCREEN_COLS];
                    end
                    for (i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++) begin
                        screen_cells[i] = attr_cell | CHR_BLANK;
                        cell_written[i] = 1'b1;
                    end
                    cursor_r = SCREEN_ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            MODE_CLEAR: begin
                for (i = 0; i < SCREEN_CELLS; i++) begin
                    screen_cells[i] = attr_cell | CHR_BLANK;
                    cell_written[i] = 1'b1;
                end
                cursor_r = 0;
                cursor_c = 0;
            end
            MODE_READ: begin
                if (req.cell_index < SCREEN_CELLS)
                    res.read_data = screen_cells[req.cell_index];
            end
            default: ;
        endcase
        res.cursor_row    = cursor_r[4:0];
        res.cursor_column = cursor_c[6:0];
        res.cursor_offset = 11'(cursor_r * SCREEN_COLS + cursor_c);
        return res;
    endfunction

    // Printable byte, now and then one of the high codes.
    function automatic logic [7:0] random_glyph();
        if ($urandom_range(7) == 0)
            return 8'($urandom_range(8'hFF, 8'h80));
        return 8'($urandom_range(8'h7E, 8'h20));
    endfunction

    // Read index that never touches a cell left unwritten since reset.
    function automatic logic [10:0] pick_read_index();
        int idx;
        if ($urandom_range(1))
            idx = cursor_r * SCREEN_COLS + cursor_c - int'($urandom_range(SCREEN_COLS, 1));
        else
            idx = $urandom_range(INDEX_ALL_ONES);
        if (idx < 0 || (idx < SCREEN_CELLS && !cell_written[idx]))
            idx = SCREEN_CELLS + $urandom_range(INDEX_ALL_ONES - SCREEN_CELLS);
        return idx[10:0];
    endfunction

    // Offer one request and hold it until accepted.
    task automatic send_item(logic [1:0] mode, logic [7:0] code, logic [10:0] idx);
        t_in req;
        req.mode       = mode;
        req.char_code  = code;
        req.cell_index = idx;
        @(negedge i_clk);
        while (send_idling && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(advance_console(req));
        if (!(mode == MODE_UNUSED || (mode == MODE_PUT && code < CHR_PRINTABLE
                && code != CHR_NEWLINE && code != CHR_RETURN
                && code != CHR_BACKSPACE && code != CHR_TAB)))
            useful_items++;
    endtask

    task automatic put_code(logic [7:0] code);
        send_item(MODE_PUT, code, 11'($urandom_range(INDEX_ALL_ONES)));
    endtask

    task automatic read_cell(logic [10:0] idx);
        send_item(MODE_READ, 8'($urandom_range(8'hFF)), idx);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register port access: setup cycle, then access cycle.
    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write both colors, update the model and read them back.
    task automatic set_colors(logic [3:0] fg, logic [3:0] bg);
        logic [31:0] rdata;
        apb_access(1'b1, ADDR_FOREGROUND, {28'd0, fg}, rdata);
        fg_color = fg;
        apb_access(1'b1, ADDR_BACKGROUND, {28'd0, bg}, rdata);
        bg_color = bg;
        apb_access(1'b0, ADDR_FOREGROUND, '0, rdata);
        if (rdata !== {28'd0, fg})
            flag_mismatch("foreground readback", rdata, fg);
        apb_access(1'b0, ADDR_BACKGROUND, '0, rdata);
        if (rdata !== {28'd0, bg})
            flag_mismatch("background readback", rdata, bg);
    endtask

    // Register write and readback at both extremes and at reset values.
    task automatic test_registers();
        logic [31:0] rdata;
        apb_access(1'b0, ADDR_FOREGROUND, '0, rdata);
        if (rdata !== 32'd7)
            flag_mismatch("foreground after reset", rdata, 7);
        apb_access(1'b0, ADDR_BACKGROUND, '0, rdata);
        if (rdata !== 32'd0)
            flag_mismatch("background after reset", rdata, 0);
        set_colors(4'hF, 4'hF);
        set_colors(4'h0, 4'h0);
        set_colors(4'hA, 4'h5);
    endtask

    // Control codes, cursor corners, high bytes, odd modes and indexes.
    task automatic test_special_cases();
        put_code(CHR_BACKSPACE);                 // backspace at home stays put
        send_item(MODE_PUT, 8'h41, INDEX_ALL_ONES);
        read_cell(11'd0);
        put_code(8'hFF);                         // high bytes stored as is
        put_code(8'h80);
        read_cell(11'd1);
        put_code(8'h00);                         // ignored control codes
        put_code(8'h1F);
        put_code(CHR_TAB);
        put_code(CHR_RETURN);
        put_code(CHR_NEWLINE);
        put_code(CHR_BACKSPACE);                 // reverse wrap to row 0, col 79
        put_code(CHR_TAB);                       // tab off the last column wraps
        read_cell(INDEX_ALL_ONES);               // out of range
        read_cell(11'(SCREEN_CELLS));
        send_item(MODE_UNUSED, 8'hAA, 11'h555);
        put_code(8'h7E);
        send_item(MODE_CLEAR, 8'hFF, INDEX_ALL_ONES);
        read_cell(11'(SCREEN_CELLS - 1));
        read_cell(11'd0);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering, then a full drain.
    task automatic test_back_pressure();
        int n;
        send_idling  = 1'b0;
        hold_off_len = HOLD_OFF_CYCLES;
        for (n = 0; n < 12; n++) begin
            if (n % 4 == 3)
                read_cell(pick_read_index());
            else
                put_code(random_glyph());
        end
        send_idling = 1'b1;
        wait_drained();
    endtask

    // Line-shaped random traffic over several color settings.
    task automatic test_random_traffic();
        int         phase;
        int         target;
        int         pick;
        int         len;
        int         n;
        logic [1:0] mode;
        for (phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: set_colors(4'hF, 4'h0);
                1: set_colors(4'h0, 4'hF);
                default: set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
            endcase
            // one phase runs with no idling on either side
            send_idling = (phase != 2);
            recv_idling = (phase != 2);
            target = useful_items + RANDOM_ITEMS / 4;
            while (useful_items < target) begin
                pick = $urandom_range(199);
                if (pick < 90) begin
                    // a text line, sometimes long enough to wrap
                    len = ($urandom_range(9) == 0) ? $urandom_range(100, 60)
                                                   : $urandom_range(30, 1);
                    for (n = 0; n < len; n++) begin
                        if ($urandom_range(19) == 0)
                            put_code(8'($urandom_range(CHR_PRINTABLE - 1)));
                        else
                            put_code(random_glyph());
                    end
                    pick = $urandom_range(99);
                    if (pick < 15)
                        put_code(CHR_RETURN);
                    if (pick < 85)
                        put_code(CHR_NEWLINE);
                end else if (pick < 110) begin
                    repeat ($urandom_range(4, 1)) put_code(CHR_NEWLINE);
                end else if (pick < 125) begin
                    repeat ($urandom_range(12, 1)) begin
                        put_code(CHR_TAB);
                        if ($urandom_range(2) == 0)
                            put_code(random_glyph());
                    end
                end else if (pick < 140) begin
                    repeat ($urandom_range(90, 1)) put_code(CHR_BACKSPACE);
                    repeat ($urandom_range(5)) put_code(random_glyph());
                end else if (pick < 175) begin
                    repeat ($urandom_range(6, 1)) read_cell(pick_read_index());
                end else if (pick == 175) begin
                    send_item(MODE_CLEAR, 8'($urandom_range(8'hFF)),
                              11'($urandom_range(INDEX_ALL_ONES)));
                end else begin
                    // noise: any mode, clear rarely, any code, any index except on reads
                    repeat ($urandom_range(8, 1)) begin
                        mode = 2'($urandom_range(3));
                        if (mode == MODE_CLEAR && $urandom_range(31) != 0)
                            mode = MODE_UNUSED;
                        send_item(mode, 8'($urandom_range(8'hFF)),
                                  (mode == MODE_READ) ? pick_read_index()
                                                      : 11'($urandom_range(INDEX_ALL_ONES)));
                    end
                end
            end
        end
        send_idling = 1'b1;
        recv_idling = 1'b1;
    endtask

    // result-side stall, with an occasional long hold-off
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_len != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off_len - 1) @(negedge i_clk);
                hold_off_len = 0;
            end else begin
                i_out_stall <= recv_idling && ($urandom_range(99) < 28);
            end
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with none expected", o_out_data, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.cursor_row !== want.cursor_row)
                        flag_mismatch("cursor_row", o_out_data.cursor_row, want.cursor_row);
                    if (o_out_data.cursor_column !== want.cursor_column)
                        flag_mismatch("cursor_column", o_out_data.cursor_column,
                                      want.cursor_column);
                    if (o_out_data.cursor_offset !== want.cursor_offset)
                        flag_mismatch("cursor_offset", o_out_data.cursor_offset,
                                      want.cursor_offset);
                    if (o_out_data.read_data !== want.read_data)
                        flag_mismatch("read_data", o_out_data.read_data, want.read_data);
                    if (o_out_data.scrolled !== want.scrolled)
                        flag_mismatch("scrolled", o_out_data.scrolled, want.scrolled);
                end
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        useful_items   = 0;
        quiet_cycles   = 0;
        hold_off_len   = 0;
        send_idling    = 1'b1;
        recv_idling    = 1'b1;
        cursor_r       = 0;
        cursor_c       = 0;
        fg_color       = 4'd7;
        bg_color       = 4'd0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_registers();
        test_special_cases();
        test_back_pressure();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
